// ----- rtl/lcnc_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// lcnc_pkg
// Shared types and constants of the Lab color nearest/centroid unit.
// -----------------------------------------------------------------------------
package lcnc_pkg;

   localparam int unsigned THR_W    = 17;
   localparam int unsigned L_W      = 15;
   localparam int unsigned AB_W     = 16;
   localparam int unsigned ENTRY_W  = L_W + 2 * AB_W;
   localparam int unsigned SQ_W     = 34;
   localparam int unsigned ROOT_W   = 17;
   localparam logic [THR_W-1:0] THR_RESET = 17'd25600;

   typedef enum logic [1:0] {
      MODE_ADD      = 2'd0,
      MODE_NEAREST  = 2'd1,
      MODE_CENTROID = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_NONE = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      AXIS_L = 2'd0,
      AXIS_A = 2'd1,
      AXIS_B = 2'd2
   } axis_type;

   typedef enum logic [2:0] {
      RSP_ADD_OK,
      RSP_FULL,
      RSP_NEAR_HIT,
      RSP_NEAR_MISS,
      RSP_CENT_OK,
      RSP_CENT_EMPTY,
      RSP_CLEAR
   } rsp_kind_type;

   typedef struct packed {
      logic         capture;
      logic         add_write;
      logic         clear_count;
      logic         scan_init;
      logic         scan_issue;
      logic         read_win;
      logic         latch_win;
      logic         sqrt_start;
      logic         div_start;
      logic         latch_quot;
      axis_type     axis;
      logic         load_rsp;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     full;
      logic     empty;
      logic     addr_done;
      logic     pipe_empty;
      logic     found;
      logic     sqrt_done;
      logic     div_done;
   } stat_type;

endpackage
`default_nettype wire

// ----- rtl/lcnc_sqrt.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// lcnc_sqrt
// Bit-pair restoring integer square root, one result bit per cycle.
// -----------------------------------------------------------------------------
module lcnc_sqrt
   import lcnc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SQ_W-1:0]   radicand,
   output logic                   done,
   output logic [ROOT_W-1:0]      root
);

   localparam int unsigned CNT_W = $clog2(ROOT_W + 1);
   localparam int unsigned REM_W = ROOT_W + 4;

   logic                run_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [SQ_W-1:0]     val_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [REM_W-1:0]    rem_sh;
   logic [REM_W-1:0]    trial;

   assign rem_sh = {rem_ff[REM_W-3:0], val_ff[SQ_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(ROOT_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         val_ff <= {val_ff[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ----- rtl/lcnc_div.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// lcnc_div
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module lcnc_div
   import lcnc_pkg::*;
#(
   parameter int unsigned NW = 25,
   parameter int unsigned DW = 9
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] numer,
   input  wire logic [DW-1:0] denom,
   output logic               done,
   output logic [NW-1:0]      quot
);

   localparam int unsigned CNT_W = $clog2(NW + 1);

   logic              run_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [NW-1:0]     num_ff;
   logic [DW-1:0]     den_ff;
   logic [DW-1:0]     rem_ff;
   logic [NW-1:0]     quot_ff;
   logic [DW:0]       rem_sh;
   logic [DW:0]       rem_sub;

   assign rem_sh  = {rem_ff, num_ff[NW-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(NW);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= numer;
         den_ff  <= denom;
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[NW-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff  <= rem_sub[DW-1:0];
            quot_ff <= {quot_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[DW-1:0];
            quot_ff <= {quot_ff[NW-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

// ----- rtl/lcnc_dpath.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// lcnc_dpath
// Sample memory, distance pipeline, sums, square root and divider.
// -----------------------------------------------------------------------------
module lcnc_dpath
   import lcnc_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output stat_type                     stat,
   input  wire logic [1:0]              req_mode,
   input  wire logic [L_W-1:0]          req_lightness,
   input  wire logic signed [AB_W-1:0]  req_green_red,
   input  wire logic signed [AB_W-1:0]  req_blue_yellow,
   input  wire logic                    csr_wr_en,
   input  wire logic [THR_W-1:0]        csr_wr_data,
   output logic [1:0]                   rsp_status,
   output logic [7:0]                   rsp_match_index,
   output logic [THR_W-1:0]             rsp_distance,
   output logic [L_W-1:0]               rsp_out_lightness,
   output logic signed [AB_W-1:0]       rsp_out_green_red,
   output logic signed [AB_W-1:0]       rsp_out_blue_yellow,
   output logic [8:0]                   rsp_entries_held
);

   localparam int unsigned AW = $clog2(MAX_ENTRIES);
   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned SW = AB_W + CW;

   // request and configuration
   mode_type                mode_ff;
   logic [L_W-1:0]          l_ff;
   logic signed [AB_W-1:0]  a_ff;
   logic signed [AB_W-1:0]  b_ff;
   logic [THR_W-1:0]        thr_ff;
   logic [CW-1:0]           count_ff;

   // memory and scan
   logic [ENTRY_W-1:0]      mem [MAX_ENTRIES];
   logic [ENTRY_W-1:0]      rd_ff;
   logic [AW-1:0]           rd_addr;
   logic [CW-1:0]           addr_ff;

   logic                    s1_v_ff, s2_v_ff, s3_v_ff;
   logic [AW-1:0]           s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [L_W-1:0]          s2_l_ff;
   logic [AB_W-1:0]         s2_a_ff, s2_b_ff;
   logic [2*L_W-1:0]        s3_l_ff;
   logic [2*AB_W-1:0]       s3_a_ff, s3_b_ff;

   logic [SQ_W-1:0]         best_ff;
   logic [AW-1:0]           win_ff;
   logic                    found_ff;

   logic [L_W-1:0]          ent_l;
   logic signed [AB_W-1:0]  ent_a, ent_b;
   logic signed [AB_W-1:0]  diff_l;
   logic signed [AB_W:0]    diff_a, diff_b;
   logic [AB_W-1:0]         mag_l;
   logic [AB_W:0]           mag_a, mag_b;
   logic [2*L_W-1:0]        sq_l;
   logic [2*AB_W-1:0]       sq_a, sq_b;
   logic [SQ_W-1:0]         dsum;
   logic [SQ_W-1:0]         thr_sq;

   // centroid
   logic signed [SW-1:0]    sum_l_ff, sum_a_ff, sum_b_ff;
   logic signed [SW-1:0]    sum_sel;
   logic [SW-1:0]           sum_mag;
   logic                    neg_ff;
   axis_type                div_axis_ff;
   logic [SW-1:0]           quot;
   logic [SW-1:0]           quot_fix;
   logic                    div_done;

   // matched entry and centroid fields
   logic [L_W-1:0]          hit_l_ff;
   logic signed [AB_W-1:0]  hit_a_ff, hit_b_ff;
   logic [L_W-1:0]          cen_l_ff;
   logic signed [AB_W-1:0]  cen_a_ff, cen_b_ff;

   logic [ROOT_W-1:0]       root;
   logic                    sqrt_done;

   // result registers
   status_type              r_status_ff;
   logic [7:0]              r_index_ff;
   logic [THR_W-1:0]        r_dist_ff;
   logic [L_W-1:0]          r_l_ff;
   logic signed [AB_W-1:0]  r_a_ff, r_b_ff;
   logic [8:0]              r_held_ff;
   logic [AW+7:0]           win_ext;
   logic [CW+8:0]           held_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THR_RESET;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (cmd.clear_count) begin
            count_ff <= '0;
         end else if (cmd.add_write) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= mode_type'(req_mode);
         l_ff    <= req_lightness;
         a_ff    <= req_green_red;
         b_ff    <= req_blue_yellow;
      end
   end

   // sample memory, one write and one registered read port
   assign rd_addr = cmd.read_win ? win_ff : addr_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.add_write) begin
         mem[count_ff[AW-1:0]] <= {l_ff, a_ff, b_ff};
      end
      rd_ff <= mem[rd_addr];
   end

   assign ent_l = rd_ff[ENTRY_W-1 -: L_W];
   assign ent_a = rd_ff[2*AB_W-1 -: AB_W];
   assign ent_b = rd_ff[AB_W-1:0];

   assign diff_l = $signed({1'b0, l_ff}) - $signed({1'b0, ent_l});
   assign diff_a = (AB_W+1)'(a_ff) - (AB_W+1)'(ent_a);
   assign diff_b = (AB_W+1)'(b_ff) - (AB_W+1)'(ent_b);
   assign mag_l  = diff_l[AB_W-1] ? -diff_l : diff_l;
   assign mag_a  = diff_a[AB_W] ? -diff_a : diff_a;
   assign mag_b  = diff_b[AB_W] ? -diff_b : diff_b;
   assign sq_l   = s2_l_ff * s2_l_ff;
   assign sq_a   = s2_a_ff * s2_a_ff;
   assign sq_b   = s2_b_ff * s2_b_ff;
   assign dsum   = SQ_W'(s3_l_ff) + SQ_W'(s3_a_ff) + SQ_W'(s3_b_ff);
   assign thr_sq = thr_ff * thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         addr_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.scan_issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         if (cmd.scan_init) begin
            addr_ff  <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.scan_issue) begin
               addr_ff <= addr_ff + 1'b1;
            end
            if (s3_v_ff && (dsum < best_ff)) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= addr_ff[AW-1:0];
      s2_idx_ff <= s1_idx_ff;
      s3_idx_ff <= s2_idx_ff;
      s2_l_ff   <= mag_l[L_W-1:0];
      s2_a_ff   <= mag_a[AB_W-1:0];
      s2_b_ff   <= mag_b[AB_W-1:0];
      s3_l_ff   <= sq_l;
      s3_a_ff   <= sq_a;
      s3_b_ff   <= sq_b;
      if (cmd.scan_init) begin
         best_ff  <= thr_sq;
         sum_l_ff <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
      end else begin
         if (s3_v_ff && (dsum < best_ff)) begin
            best_ff <= dsum;
            win_ff  <= s3_idx_ff;
         end
         if (s1_v_ff) begin
            sum_l_ff <= sum_l_ff + $signed(SW'(ent_l));
            sum_a_ff <= sum_a_ff + SW'(ent_a);
            sum_b_ff <= sum_b_ff + SW'(ent_b);
         end
      end
   end

   // centroid division: magnitude through the divider, sign restored after
   always_comb begin
      unique case (cmd.axis)
         AXIS_L:  sum_sel = sum_l_ff;
         AXIS_A:  sum_sel = sum_a_ff;
         default: sum_sel = sum_b_ff;
      endcase
   end

   assign sum_mag  = sum_sel[SW-1] ? -sum_sel : sum_sel;
   assign quot_fix = neg_ff ? -quot : quot;

   lcnc_div #(
      .NW (SW),
      .DW (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (sum_mag),
      .denom (count_ff),
      .done  (div_done),
      .quot  (quot)
   );

   lcnc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (best_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   // hold the axis of the running division; the next start may change cmd.axis
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff      <= sum_sel[SW-1];
         div_axis_ff <= cmd.axis;
      end
      if (cmd.latch_quot) begin
         unique case (div_axis_ff)
            AXIS_L:  cen_l_ff <= quot_fix[L_W-1:0];
            AXIS_A:  cen_a_ff <= quot_fix[AB_W-1:0];
            default: cen_b_ff <= quot_fix[AB_W-1:0];
         endcase
      end
      if (cmd.latch_win) begin
         hit_l_ff <= ent_l;
         hit_a_ff <= ent_a;
         hit_b_ff <= ent_b;
      end
   end

   assign win_ext  = (AW+8)'(win_ff);
   assign held_ext = (CW+9)'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         r_status_ff <= STAT_OK;
         r_index_ff  <= '0;
         r_dist_ff   <= '0;
         r_l_ff      <= '0;
         r_a_ff      <= '0;
         r_b_ff      <= '0;
         r_held_ff   <= held_ext[8:0];
         unique case (cmd.rsp_kind)
            RSP_FULL: begin
               r_status_ff <= STAT_FULL;
            end
            RSP_NEAR_HIT: begin
               r_index_ff <= win_ext[7:0];
               r_dist_ff  <= root;
               r_l_ff     <= hit_l_ff;
               r_a_ff     <= hit_a_ff;
               r_b_ff     <= hit_b_ff;
            end
            RSP_NEAR_MISS: begin
               r_status_ff <= STAT_NONE;
               r_dist_ff   <= thr_ff;
            end
            RSP_CENT_OK: begin
               r_l_ff <= cen_l_ff;
               r_a_ff <= cen_a_ff;
               r_b_ff <= cen_b_ff;
            end
            RSP_CENT_EMPTY: begin
               r_status_ff <= STAT_NONE;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_status          = r_status_ff;
   assign rsp_match_index     = r_index_ff;
   assign rsp_distance        = r_dist_ff;
   assign rsp_out_lightness   = r_l_ff;
   assign rsp_out_green_red   = r_a_ff;
   assign rsp_out_blue_yellow = r_b_ff;
   assign rsp_entries_held    = r_held_ff;

   assign stat.mode       = mode_ff;
   assign stat.full       = (count_ff == CW'(MAX_ENTRIES));
   assign stat.empty      = (count_ff == '0);
   assign stat.addr_done  = (addr_ff == count_ff);
   assign stat.pipe_empty = !(s1_v_ff || s2_v_ff || s3_v_ff);
   assign stat.found      = found_ff;
   assign stat.sqrt_done  = sqrt_done;
   assign stat.div_done   = div_done;

endmodule
`default_nettype wire

// ----- rtl/lcnc_ctrl.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// lcnc_ctrl
// Operation sequencer: dispatch, scan, square root or divisions, respond.
// -----------------------------------------------------------------------------
module lcnc_ctrl
   import lcnc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   output logic          rsp_strobe,
   output cmd_type       cmd,
   input  wire stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_FETCH,
      ST_SQRT,
      ST_DIV,
      ST_RESPOND
   } state_type;

   state_type    state_ff, state_in;
   axis_type     axis_ff, axis_in;
   rsp_kind_type kind_ff, kind_in;
   logic         strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         axis_ff   <= AXIS_L;
         kind_ff   <= RSP_CLEAR;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         axis_ff   <= axis_in;
         kind_ff   <= kind_in;
         strobe_ff <= (state_ff == ST_RESPOND);
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.axis     = axis_ff;
      cmd.rsp_kind = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.mode)
               MODE_ADD: begin
                  state_in = ST_RESPOND;
                  if (stat.full) begin
                     kind_in = RSP_FULL;
                  end else begin
                     cmd.add_write = 1'b1;
                     kind_in       = RSP_ADD_OK;
                  end
               end
               MODE_NEAREST: begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
               MODE_CENTROID: begin
                  if (stat.empty) begin
                     kind_in  = RSP_CENT_EMPTY;
                     state_in = ST_RESPOND;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end
               default: begin
                  cmd.clear_count = 1'b1;
                  kind_in         = RSP_CLEAR;
                  state_in        = ST_RESPOND;
               end
            endcase
         end
         ST_SCAN: begin
            priority if (!stat.addr_done) begin
               cmd.scan_issue = 1'b1;
            end else if (stat.pipe_empty) begin
               priority if (stat.mode == MODE_CENTROID) begin
                  axis_in       = AXIS_L;
                  cmd.axis      = AXIS_L;
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end else if (stat.found) begin
                  cmd.read_win = 1'b1;
                  state_in     = ST_FETCH;
               end else begin
                  kind_in  = RSP_NEAR_MISS;
                  state_in = ST_RESPOND;
               end
            end else begin
            end
         end
         ST_FETCH: begin
            cmd.latch_win  = 1'b1;
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQRT;
         end
         ST_SQRT: begin
            if (stat.sqrt_done) begin
               kind_in  = RSP_NEAR_HIT;
               state_in = ST_RESPOND;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.latch_quot = 1'b1;
               unique case (axis_ff)
                  AXIS_L: begin
                     axis_in       = AXIS_A;
                     cmd.div_start = 1'b1;
                  end
                  AXIS_A: begin
                     axis_in       = AXIS_B;
                     cmd.div_start = 1'b1;
                  end
                  default: begin
                     kind_in  = RSP_CENT_OK;
                     state_in = ST_RESPOND;
                  end
               endcase
            end
         end
         ST_RESPOND: begin
            cmd.load_rsp = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // next divide picks its operand by the new axis
      if (cmd.div_start) begin
         cmd.axis = axis_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule
`default_nettype wire

// ----- rtl/lab_color_nearest_and_centroid_unit.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// lab_color_nearest_and_centroid_unit
// Table of Lab color samples (Q8): add, clear, nearest by CIE76 distance
// against a threshold, and per-axis centroid.
// -----------------------------------------------------------------------------
//
//   channel   ports                     transfer when
//   --------  ------------------------  ---------------------------
//   request   start, busy, req_*        start high and busy low
//   result    rsp_strobe, rsp_*         rsp_strobe high (one cycle)
//   config    csr_wr_en, csr_wr_data    csr_wr_en high
//
// Steps of each item, request transfer to strobe:
//   add, clear, centroid of an empty table: dispatch, then respond
//   nearest: scan of the N entries held, one entry per cycle; on a match,
//     a read of the winner and the 17-step square root; then respond
//   centroid: the same scan, then three divisions (L, a, b) on the serial
//     divider of NW = 16 + clog2(MAX_ENTRIES + 1) bits; then respond
// Reset is synchronous; it clears the count and the control state and
// loads the threshold. The sample memory needs no clearing pass. The result
// cannot be stalled: it is shown for one cycle and busy is already low, so
// the next start is taken then.
// -----------------------------------------------------------------------------
module lab_color_nearest_and_centroid_unit
   import lcnc_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [1:0]              req_mode,
   input  wire logic [L_W-1:0]          req_lightness,
   input  wire logic signed [AB_W-1:0]  req_green_red,
   input  wire logic signed [AB_W-1:0]  req_blue_yellow,
   input  wire logic                    csr_wr_en,
   input  wire logic [THR_W-1:0]        csr_wr_data,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [7:0]                   rsp_match_index,
   output logic [THR_W-1:0]             rsp_distance,
   output logic [L_W-1:0]               rsp_out_lightness,
   output logic signed [AB_W-1:0]       rsp_out_green_red,
   output logic signed [AB_W-1:0]       rsp_out_blue_yellow,
   output logic [8:0]                   rsp_entries_held
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: one operation at a time
   lcnc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   // memory, distance pipeline, sums and the arithmetic units
   lcnc_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req_mode),
      .req_lightness       (req_lightness),
      .req_green_red       (req_green_red),
      .req_blue_yellow     (req_blue_yellow),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_status          (rsp_status),
      .rsp_match_index     (rsp_match_index),
      .rsp_distance        (rsp_distance),
      .rsp_out_lightness   (rsp_out_lightness),
      .rsp_out_green_red   (rsp_out_green_red),
      .rsp_out_blue_yellow (rsp_out_blue_yellow),
      .rsp_entries_held    (rsp_entries_held)
   );

`ifndef SYNTHESIS
   // a result strobe always falls right after it rises
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // a taken request always keeps the unit busy for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not raise busy");

   // results are shown only once the unit is back to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // a no-match or empty-table result always carries index zero
   a_none_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STAT_NONE)) |-> (rsp_match_index == 8'd0))
      else $error("no-match result carries an index");
`endif

endmodule
`default_nettype wire
